### rtl/core/receiver_token_queue_macros.svh
// Assertion macros shared by the token queue RTL.
// Each macro checks a property on the rising edge of i_clk and is
// switched off while i_rst_n is low.
`ifndef RECEIVER_TOKEN_QUEUE_MACROS_SVH
`define RECEIVER_TOKEN_QUEUE_MACROS_SVH

`ifndef SYNTHESIS
// Antecedent and consequent in the same cycle.
`define RTQ_ASSERT_SAME(lbl, ant, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error("token queue assertion failed");
// Consequent in the cycle after the antecedent.
`define RTQ_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error("token queue assertion failed");
`else
`define RTQ_ASSERT_SAME(lbl, ant, cons)
`define RTQ_ASSERT_NEXT(lbl, ant, cons)
`endif

`endif

### rtl/core/rtq_pkg.sv
`default_nettype none

package rtq_pkg;

    // Field widths of the request and result records.
    localparam int RANK_W     = 6;
    localparam int FUNC_W     = 2;
    localparam int SLOTS_W    = 7;
    localparam int HW_W       = 7;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int MASK_W     = 64;

    // Position generator and remainder unit.
    localparam int LFSR_W     = 32;
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;
    localparam int DIV_BITS   = 4;

    localparam int DEFAULT_QUEUE_DEPTH = 64;

    // Request function codes.
    localparam logic [FUNC_W-1:0] FUNC_ADD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SNAP = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RET  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED = 2'd1;

    typedef logic [RANK_W-1:0] t_rank;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        t_rank              rank;
        logic [SLOTS_W-1:0] slots_free;
        logic               batch_start;
    } t_req;

    typedef struct packed {
        t_rank              token_rank;
        logic               token_valid;
        logic               last;
        logic [HW_W-1:0]    high_water;
        logic               overflow;
    } t_res;

    // Control broadcast to every slot of the chain.
    typedef struct packed {
        logic  ins;
        logic  drain;
        t_rank tok;
    } t_slot_ctl;

    // One step of the Galois LFSR, shifting right.
    function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
        logic [LFSR_W-1:0] s;
        s = v >> 1;
        if (v[0]) begin
            s = s ^ LFSR_TAPS;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

### rtl/core/rtq_slot.sv
`default_nettype none

// One slot of the token chain. On an insert, slots at or above the
// insert position move one place toward the tail; on a drain every
// slot takes its tail-side neighbor.
module rtq_slot #(
    parameter int INDEX = 0,
    parameter int POS_W = 7
) (
    input  wire logic              i_clk,
    input  wire rtq_pkg::t_slot_ctl i_ctl,
    input  wire logic [POS_W-1:0]  i_pos,
    input  wire rtq_pkg::t_rank    i_left,
    input  wire rtq_pkg::t_rank    i_right,
    output logic [rtq_pkg::RANK_W-1:0] o_tok
);
    import rtq_pkg::*;

    localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

    t_rank r_tok;
    t_rank n_tok;

    // Choose the next content of this slot.
    always_comb begin
        n_tok = r_tok;
        if (i_ctl.drain) begin
            n_tok = i_right;
        end else if (i_ctl.ins) begin
            if (MY_POS == i_pos) begin
                n_tok = i_ctl.tok;
            end else if (MY_POS > i_pos) begin
                n_tok = i_left;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

### rtl/core/rtq_div.sv
`default_nettype none

`include "receiver_token_queue_macros.svh"

// Remainder of a 32-bit value by the fill count, restoring method,
// DIV_BITS quotient bits per cycle.
module rtq_div #(
    parameter int POS_W = 7
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [rtq_pkg::LFSR_W-1:0] i_dividend,
    input  wire logic [POS_W-1:0]           i_divisor,
    output logic                            o_done,
    output logic [POS_W-1:0]                o_rem
);
    import rtq_pkg::*;

    localparam int STEPS = LFSR_W / DIV_BITS;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_step;
    logic [LFSR_W-1:0] r_dvd;
    logic [POS_W-1:0]  r_dvs;
    logic [POS_W-1:0]  r_rem;

    logic [LFSR_W-1:0] n_dvd;
    logic [POS_W:0]    w_rem;

    // A few dependent shift-and-subtract steps per cycle.
    always_comb begin
        w_rem = {1'b0, r_rem};
        n_dvd = r_dvd;
        for (int i = 0; i < DIV_BITS; i++) begin
            w_rem = {w_rem[POS_W-1:0], n_dvd[LFSR_W-1]};
            n_dvd = n_dvd << 1;
            if (w_rem >= {1'b0, r_dvs}) begin
                w_rem = w_rem - {1'b0, r_dvs};
            end
        end
    end

    // Control of the iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath of the iteration.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= n_dvd;
            r_rem <= w_rem[POS_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

    `RTQ_ASSERT_NEXT(a_done_after_busy, !r_busy, !r_done)
    `RTQ_ASSERT_SAME(a_rem_below_divisor, r_done, r_rem < r_dvs)

endmodule

`default_nettype wire

### rtl/core/receiver_token_queue.sv
// Receiver token queue.
// Requests arrive on i_req and are taken at a clock edge with start high and
// busy low. An add appends one token, or inserts slots_free tokens at
// pseudo-random positions; a return puts one token back near the head; a
// snapshot drains the queue in order on o_res, one result per cycle marked
// by o_res_valid, with last on the final one.
// An append, a return, an ignored request and an empty snapshot leave busy
// low, so a new request may follow at once; an empty snapshot shows its
// result in the cycle after acceptance. A snapshot holds busy until its last
// token is drained; its first result passes the state and result registers.
// A multi-token add holds busy until every token is done: each token steps
// the generator, then goes to the head of an empty queue, is dropped by a
// full one, or is inserted where the remainder unit picks.
// The user must write configuration (i_cfg_we, i_cfg_idx, i_cfg_data) only
// while the block is idle; the block itself does not enforce this. Writing
// the seed reloads the position generator.
// After reset the queue is empty, no ranks are enabled and the seed is one.
// Results are shown for exactly one cycle; the receiver cannot stall them.
`default_nettype none

`include "receiver_token_queue_macros.svh"

module receiver_token_queue #(
    parameter int QUEUE_DEPTH = rtq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire rtq_pkg::t_req                  i_req,
    output logic                                o_res_valid,
    output rtq_pkg::t_res                       o_res,
    input  wire logic                           i_cfg_we,
    input  wire logic [rtq_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rtq_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rtq_pkg::*;

    localparam int POS_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [POS_W-1:0] DEPTH_C = POS_W'(QUEUE_DEPTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_STEP  = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_DRAIN = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [POS_W-1:0]   r_fill, n_fill;
    logic [POS_W-1:0]   r_peak, n_peak;
    logic [POS_W-1:0]   r_ret, n_ret;
    logic [POS_W-1:0]   r_left, n_left;
    logic [SLOTS_W-1:0] r_cnt, n_cnt;
    logic [LFSR_W-1:0]  r_lfsr, n_lfsr;
    logic [MASK_W-1:0]  r_mask;
    logic               r_drop, n_drop;
    logic               r_ov, n_ov;
    t_rank              r_tok, n_tok;
    logic               r_res_valid, n_res_valid;
    t_res               r_res, n_res;

    logic               w_acc;
    logic               w_full;
    logic               w_tok_done;
    logic [POS_W-1:0]   w_base;
    logic               w_div_start;
    logic               w_div_done;
    logic [POS_W-1:0]   w_div_rem;
    t_slot_ctl          w_ctl;
    logic [POS_W-1:0]   w_pos;
    t_rank              w_slot [QUEUE_DEPTH];

    assign busy   = (r_state != S_IDLE);
    assign w_acc  = start && !busy;
    assign w_full = (r_fill == DEPTH_C);

    // Position of a returned token: the head for a new batch, else the
    // saved position clamped to the current fill.
    assign w_base = i_req.batch_start ? '0 : ((r_ret > r_fill) ? r_fill : r_ret);

    // Request decode and sequencing.
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_peak      = r_peak;
        n_ret       = r_ret;
        n_left      = r_left;
        n_cnt       = r_cnt;
        n_lfsr      = r_lfsr;
        n_drop      = r_drop;
        n_ov        = r_ov;
        n_tok       = r_tok;
        n_res_valid = 1'b0;
        n_res       = r_res;
        w_tok_done  = 1'b0;
        w_div_start = 1'b0;
        w_ctl.ins   = 1'b0;
        w_ctl.drain = 1'b0;
        w_ctl.tok   = r_tok;
        w_pos       = '0;

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (i_req.func)
                        FUNC_ADD: begin
                            if (r_mask[i_req.rank]) begin
                                if (i_req.slots_free == SLOTS_W'(1)) begin
                                    if (w_full) begin
                                        n_drop = 1'b1;
                                    end else begin
                                        w_ctl.ins = 1'b1;
                                        w_ctl.tok = i_req.rank;
                                        w_pos     = r_fill;
                                        n_fill    = r_fill + 1'b1;
                                    end
                                end else if (i_req.slots_free != '0) begin
                                    n_cnt   = i_req.slots_free;
                                    n_tok   = i_req.rank;
                                    n_state = S_STEP;
                                end
                            end
                        end
                        FUNC_SNAP: begin
                            n_ov   = r_drop;
                            n_drop = 1'b0;
                            if (r_fill == '0) begin
                                n_res_valid       = 1'b1;
                                n_res.token_rank  = '0;
                                n_res.token_valid = 1'b0;
                                n_res.last        = 1'b1;
                                n_res.high_water  = HW_W'(r_peak);
                                n_res.overflow    = r_drop;
                            end else begin
                                n_left  = r_fill;
                                n_fill  = '0;
                                n_state = S_DRAIN;
                            end
                        end
                        FUNC_RET: begin
                            if (w_full) begin
                                n_drop = 1'b1;
                                n_ret  = w_base;
                            end else begin
                                w_ctl.ins = 1'b1;
                                w_ctl.tok = i_req.rank;
                                w_pos     = w_base;
                                n_fill    = r_fill + 1'b1;
                                n_ret     = w_base + 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_STEP: begin
                n_lfsr = lfsr_next(r_lfsr);
                if (w_full) begin
                    n_drop     = 1'b1;
                    w_tok_done = 1'b1;
                end else if (r_fill == '0) begin
                    w_ctl.ins  = 1'b1;
                    w_pos      = '0;
                    n_fill     = r_fill + 1'b1;
                    w_tok_done = 1'b1;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    w_ctl.ins  = 1'b1;
                    w_pos      = w_div_rem;
                    n_fill     = r_fill + 1'b1;
                    w_tok_done = 1'b1;
                end
            end
            S_DRAIN: begin
                w_ctl.drain       = 1'b1;
                n_res_valid       = 1'b1;
                n_res.token_rank  = w_slot[0];
                n_res.token_valid = 1'b1;
                n_res.last        = (r_left == POS_W'(1));
                n_res.high_water  = HW_W'(r_peak);
                n_res.overflow    = r_ov;
                n_left            = r_left - 1'b1;
                if (r_left == POS_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // One token of a multi-token add finished.
        if (w_tok_done) begin
            n_cnt   = r_cnt - 1'b1;
            n_state = (r_cnt == SLOTS_W'(1)) ? S_IDLE : S_STEP;
        end

        // Track the highest fill.
        if (n_fill > r_peak) begin
            n_peak = n_fill;
        end

        // A seed write reloads the generator; zero counts as one.
        if (i_cfg_we && i_cfg_idx == REG_SEED) begin
            n_lfsr = (i_cfg_data[LFSR_W-1:0] == '0) ? LFSR_W'(1) : i_cfg_data[LFSR_W-1:0];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_peak      <= '0;
            r_ret       <= '0;
            r_left      <= '0;
            r_cnt       <= '0;
            r_lfsr      <= LFSR_W'(1);
            r_drop      <= 1'b0;
            r_ov        <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_peak      <= n_peak;
            r_ret       <= n_ret;
            r_left      <= n_left;
            r_cnt       <= n_cnt;
            r_lfsr      <= n_lfsr;
            r_drop      <= n_drop;
            r_ov        <= n_ov;
            r_res_valid <= n_res_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
        r_res <= n_res;
    end

    // Rank enable register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_cfg_we && i_cfg_idx == REG_MASK) begin
            r_mask <= i_cfg_data[MASK_W-1:0];
        end
    end

    // Remainder unit for random insert positions.
    rtq_div #(
        .POS_W (POS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (n_lfsr),
        .i_divisor  (r_fill),
        .o_done     (w_div_done),
        .o_rem      (w_div_rem)
    );

    // Chain of token slots, head at index zero.
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_slot
        t_rank w_left;
        t_rank w_right;
        if (g == 0) begin : g_head
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_slot[g-1];
        end
        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_slot[g+1];
        end
        rtq_slot #(
            .INDEX (g),
            .POS_W (POS_W)
        ) u_slot (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_pos   (w_pos),
            .i_left  (w_left),
            .i_right (w_right),
            .o_tok   (w_slot[g])
        );
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    `RTQ_ASSERT_SAME(a_fill_bound, 1'b1, r_fill <= DEPTH_C)
    `RTQ_ASSERT_NEXT(a_res_source, !(w_acc && i_req.func == FUNC_SNAP) && r_state != S_DRAIN, !o_res_valid)
    `RTQ_ASSERT_NEXT(a_drain_end, r_state == S_DRAIN && r_left == POS_W'(1), o_res.last && !busy)
    `RTQ_ASSERT_NEXT(a_div_wait, r_state == S_DIV && !w_div_done, r_state == S_DIV && r_fill == $past(r_fill))

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import rtq_pkg::*;

    localparam int QUEUE_DEPTH   = 64;
    // Long enough for a 127-token add to finish.
    localparam int SETTLE_CYCLES = 1300;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int PHASE_ITEMS   = 100;
    localparam int REQ_W         = $bits(t_req);

    // Codes that the package leaves out: the ignored function and register indexes.
    localparam logic [FUNC_W-1:0]    FUNC_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_req                  i_req;
    logic                  o_res_valid;
    t_res                  o_res;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Shadow copy of the queue state and registers.
    t_rank       queue_copy [QUEUE_DEPTH];
    int          fill_copy = 0;
    int          peak_copy = 0;
    int          return_pos_copy = 0;
    bit          dropped_copy = 1'b0;
    logic [31:0] lfsr_copy = 32'd1;
    logic [63:0] mask_copy = '0;

    // Drained tokens still to come out of the block, oldest first.
    t_res drained_tokens_due[$];

    int error_count = 0;
    int cycle_count = 0;
    bit steady = 1'b0;
    bit request_took_effect;

    receiver_token_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Guard against a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    // Compare every drained token with the oldest one still due.
    always @(posedge i_clk) begin : check_drained_tokens
        t_res want;
        if (i_rst_n && o_res_valid) begin
            if (drained_tokens_due.size() == 0) begin
                flag_error($sformatf("unexpected drain result: rank %0d valid %0b last %0b",
                                     o_res.token_rank, o_res.token_valid, o_res.last));
            end else begin
                want = drained_tokens_due.pop_front();
                if (o_res.token_rank !== want.token_rank ||
                    o_res.token_valid !== want.token_valid ||
                    o_res.last !== want.last ||
                    o_res.high_water !== want.high_water ||
                    o_res.overflow !== want.overflow) begin
                    flag_error($sformatf({"drain mismatch: expected rank %0d valid %0b last %0b ",
                                          "hw %0d ovf %0b, got rank %0d valid %0b last %0b ",
                                          "hw %0d ovf %0b"},
                                         want.token_rank, want.token_valid, want.last,
                                         want.high_water, want.overflow,
                                         o_res.token_rank, o_res.token_valid, o_res.last,
                                         o_res.high_water, o_res.overflow));
                end
            end
        end
    end

    // Insert one token into the shadow queue; a full queue drops it.
    function automatic bit place_token(input int pos, input t_rank r);
        if (fill_copy >= QUEUE_DEPTH) begin
            dropped_copy = 1'b1;
            return 1'b0;
        end
        if (pos > fill_copy) begin
            pos = fill_copy;
        end
        for (int i = fill_copy; i > pos; i--) begin
            queue_copy[i] = queue_copy[i - 1];
        end
        queue_copy[pos] = r;
        fill_copy++;
        return 1'b1;
    endfunction

    // Advance the shadow queue by one request; returns 0 when it is ignored.
    function automatic bit update_token_queue(input t_req r);
        t_res res;
        int   pos;
        bit   shifted_out;
        case (r.func)
            FUNC_ADD: begin
                if (!mask_copy[r.rank]) begin
                    return 1'b0;
                end
                if (r.slots_free == 7'd1) begin
                    void'(place_token(fill_copy, r.rank));
                end else begin
                    for (int i = 0; i < r.slots_free; i++) begin
                        shifted_out = lfsr_copy[0];
                        lfsr_copy = lfsr_copy >> 1;
                        if (shifted_out) begin
                            lfsr_copy = lfsr_copy ^ LFSR_TAPS;
                        end
                        pos = (fill_copy == 0) ? 0 : int'(lfsr_copy % 32'(fill_copy));
                        void'(place_token(pos, r.rank));
                    end
                end
            end
            FUNC_SNAP: begin
                res.high_water = 7'(peak_copy);
                res.overflow   = dropped_copy;
                if (fill_copy == 0) begin
                    res.token_rank  = '0;
                    res.token_valid = 1'b0;
                    res.last        = 1'b1;
                    drained_tokens_due = {drained_tokens_due, res};
                end else begin
                    for (int k = 0; k < fill_copy; k++) begin
                        res.token_rank  = queue_copy[k];
                        res.token_valid = 1'b1;
                        res.last        = (k == fill_copy - 1);
                        drained_tokens_due = {drained_tokens_due, res};
                    end
                end
                fill_copy    = 0;
                dropped_copy = 1'b0;
            end
            FUNC_RET: begin
                if (r.batch_start) begin
                    return_pos_copy = 0;
                end
                if (return_pos_copy > fill_copy) begin
                    return_pos_copy = fill_copy;
                end
                if (place_token(return_pos_copy, r.rank)) begin
                    return_pos_copy++;
                end
            end
            default: begin
                return 1'b0;
            end
        endcase
        if (fill_copy > peak_copy) begin
            peak_copy = fill_copy;
        end
        return 1'b1;
    endfunction

    function automatic t_req make_req(input logic [FUNC_W-1:0] func, input t_rank rank,
                                      input logic [SLOTS_W-1:0] slots, input logic head);
        t_req r;
        r.func        = func;
        r.rank        = rank;
        r.slots_free  = slots;
        r.batch_start = head;
        return r;
    endfunction

    // Send a request, after random idle cycles unless steady, and wait until taken.
    task automatic send_request(input t_req r);
        logic [REQ_W-1:0] noise;
        if (!steady) begin
            while ($urandom_range(0, 99) < 15) begin
                noise = REQ_W'($urandom);
                start <= 1'b0;
                i_req <= noise;
                @(posedge i_clk);
            end
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        request_took_effect = update_token_queue(r);
    endtask

    // Let every due token drain and any long add finish.
    task automatic wait_idle();
        start <= 1'b0;
        while (drained_tokens_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Leaves the write enable high so that writes can follow back to back.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == REG_MASK) begin
            mask_copy = data;
        end else if (idx == REG_SEED) begin
            lfsr_copy = (data[31:0] == 32'd0) ? 32'd1 : data[31:0];
        end
    endtask

    task automatic close_registers();
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= 2'($urandom);
        i_cfg_data <= {$urandom, $urandom};
    endtask

    // After reset no rank is enabled, so an add is ignored and the queue drains empty.
    task automatic test_reset_state();
        send_request(make_req(FUNC_ADD, 6'd5, 7'd1, 1'b0));
        send_request(make_req(FUNC_SNAP, 6'd0, 7'd0, 1'b0));
    endtask

    // Zero mask, all-ones seed and writes to unused indexes; then enable all ranks.
    task automatic test_register_writes();
        wait_idle();
        write_register(REG_MASK, '0);
        write_register(REG_SEED, '1);
        write_register(REG_SPARE_LO, '1);
        write_register(REG_SPARE_HI, '1);
        close_registers();
        send_request(make_req(FUNC_ADD, 6'd63, 7'd3, 1'b1));
        send_request(make_req(FUNC_SNAP, 6'd63, 7'd127, 1'b1));
        wait_idle();
        write_register(REG_MASK, '1);
        write_register(REG_SEED, {32'hFFFF_FFFF, 32'd0});
        close_registers();
    endtask

    // Single-token adds append in arrival order.
    task automatic test_append_order();
        send_request(make_req(FUNC_ADD, 6'd0, 7'd1, 1'b0));
        send_request(make_req(FUNC_ADD, 6'd63, 7'd1, 1'b1));
        send_request(make_req(FUNC_ADD, 6'd42, 7'd1, 1'b0));
        send_request(make_req(FUNC_SNAP, 6'd21, 7'd64, 1'b0));
    endtask

    // Multi-token adds: zero tokens, an insert into an empty queue, and an ignored code.
    task automatic test_random_insert();
        send_request(make_req(FUNC_ADD, 6'd7, 7'd0, 1'b0));
        send_request(make_req(FUNC_ADD, 6'd9, 7'd2, 1'b0));
        send_request(make_req(FUNC_ADD, 6'd21, 7'd5, 1'b1));
        send_request(make_req(FUNC_SNAP, 6'd0, 7'd0, 1'b0));
        send_request(make_req(FUNC_UNUSED, 6'd63, 7'd127, 1'b1));
        send_request(make_req(FUNC_SNAP, 6'd0, 7'd0, 1'b0));
    endtask

    // Returned batches go to the head in order; a stale position is clamped.
    task automatic test_returns();
        send_request(make_req(FUNC_ADD, 6'd1, 7'd1, 1'b0));
        send_request(make_req(FUNC_ADD, 6'd2, 7'd1, 1'b0));
        send_request(make_req(FUNC_RET, 6'd60, 7'd0, 1'b1));
        send_request(make_req(FUNC_RET, 6'd61, 7'd127, 1'b0));
        send_request(make_req(FUNC_RET, 6'd62, 7'd1, 1'b0));
        send_request(make_req(FUNC_SNAP, 6'd0, 7'd0, 1'b0));
        send_request(make_req(FUNC_RET, 6'd44, 7'd0, 1'b0));
        send_request(make_req(FUNC_SNAP, 6'd0, 7'd0, 1'b0));
    endtask

    // Fill the queue, drop adds and a return, then see the sticky flag clear.
    task automatic test_overflow();
        send_request(make_req(FUNC_ADD, 6'd3, 7'd64, 1'b0));
        send_request(make_req(FUNC_ADD, 6'd4, 7'd127, 1'b0));
        send_request(make_req(FUNC_ADD, 6'd5, 7'd1, 1'b0));
        send_request(make_req(FUNC_RET, 6'd6, 7'd0, 1'b1));
        send_request(make_req(FUNC_SNAP, 6'd0, 7'd0, 1'b0));
        send_request(make_req(FUNC_SNAP, 6'd0, 7'd0, 1'b0));
    endtask

    // Random traffic over several register settings; one phase runs without idling.
    task automatic test_random_traffic();
        logic [63:0] mask_val;
        logic [63:0] seed_val;
        int          done;
        int          roll;
        t_rank       rank;
        logic [6:0]  slots;
        t_req        r;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    mask_val = '1;
                    seed_val = {$urandom, 32'hFFFF_FFFF};
                end
                1: begin
                    mask_val = {$urandom, $urandom};
                    seed_val = {$urandom, $urandom};
                end
                2: begin
                    mask_val = {1'b1, 62'd0, 1'b1};
                    seed_val = 64'd1;
                end
                3: begin
                    mask_val = {$urandom, $urandom};
                    seed_val = {$urandom, 32'd0};
                end
                default: begin
                    mask_val = '1;
                    seed_val = {$urandom, $urandom};
                end
            endcase
            wait_idle();
            write_register(REG_MASK, mask_val);
            write_register(REG_SEED, seed_val);
            close_registers();
            steady = (phase == 2);
            done = 0;
            while (done < PHASE_ITEMS) begin
                roll = $urandom_range(0, 99);
                rank = RANK_W'($urandom_range(0, 63));
                if (roll < 50) begin
                    // Mostly from enabled ranks, so that adds land.
                    if (mask_copy != '0 && $urandom_range(0, 9) != 0) begin
                        while (!mask_copy[rank]) begin
                            rank = rank + 1'b1;
                        end
                    end
                    roll = $urandom_range(0, 99);
                    if (roll < 60) begin
                        slots = 7'd1;
                    end else if (roll < 85) begin
                        slots = SLOTS_W'($urandom_range(0, 6));
                    end else if (roll < 97) begin
                        slots = SLOTS_W'($urandom_range(7, 40));
                    end else begin
                        slots = SLOTS_W'($urandom_range(41, 127));
                    end
                    r = make_req(FUNC_ADD, rank, slots, 1'($urandom));
                end else if (roll < 72) begin
                    r = make_req(FUNC_RET, rank, 7'($urandom),
                                 ($urandom_range(0, 3) == 0));
                end else if (roll < 88) begin
                    r = make_req(FUNC_SNAP, rank, 7'($urandom), 1'($urandom));
                end else begin
                    r = REQ_W'($urandom);
                end
                send_request(r);
                if (request_took_effect) begin
                    done++;
                end
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_req      <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_register_writes();
        test_append_order();
        test_random_insert();
        test_returns();
        test_overflow();
        test_random_traffic();

        wait_idle();
        if (error_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
